// ----- design/pms_pkg.sv -----
// Package for the polygon minimum separation block: sizes, command and status codes,
// and the sequencer state type.
// Used by every module in the design folder.
package pms_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W = 24;
    localparam int EDGE_W = 25;
    localparam int NORM_W = 16;
    localparam int SEP_W = 26;
    localparam int PROJ_W = 28;
    localparam int PROD_W = 2 * EDGE_W;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_A_EMPTY = 2'd1;
    localparam logic [1:0] ST_B_EMPTY = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_A0,
        S_A1,
        S_A2,
        S_SQ0,
        S_SQ1,
        S_SQ2,
        S_SQW,
        S_DX,
        S_DXW,
        S_DY,
        S_DYW,
        S_B0,
        S_B1,
        S_P0,
        S_P1,
        S_P2,
        S_EDGE,
        S_OUT
    } pms_state_t;

endpackage

// ----- design/pms_sqrt.sv -----
// Iterative integer square root, two radicand bits per cycle.
// Depends on pms_pkg for the operand widths.
module pms_sqrt
    import pms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PROD_W-1:0]   radicand,
    output logic                done,
    output logic [EDGE_W-1:0]   root
);

    logic [PROD_W-1:0] rad_reg, rad_next;
    logic [EDGE_W:0]   rem_reg, rem_next;
    logic [EDGE_W-1:0] root_reg, root_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [EDGE_W+2:0] rem_sh;
    logic [EDGE_W+2:0] trial;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[PROD_W-1:PROD_W-2]};
        trial = {1'b0, root_reg, 2'b01};
        rad_next = rad_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next = radicand;
            rem_next = '0;
            root_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[PROD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next = (EDGE_W+1)'(rem_sh - trial);
                root_next = {root_reg[EDGE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[EDGE_W:0];
                root_next = {root_reg[EDGE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(EDGE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- design/pms_div.sv -----
// Iterative restoring divider for the normal components: round(mag * 2^15 / len).
// Depends on pms_pkg for the operand widths.
module pms_div
    import pms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [EDGE_W-1:0]   mag,
    input  logic [EDGE_W-1:0]   divisor,
    output logic                done,
    output logic [NORM_W-1:0]   quotient
);

    logic [39:0]       num;
    logic [NORM_W-1:0] low_reg, low_next;
    logic [EDGE_W-1:0] rem_reg, rem_next;
    logic [EDGE_W-1:0] dvs_reg, dvs_next;
    logic [NORM_W-1:0] q_reg, q_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [EDGE_W:0]   rem_sh;

    always_comb
    begin
        num = {mag[EDGE_W-1:0], 15'd0} + 40'(divisor >> 1);
        rem_sh = {rem_reg, low_reg[NORM_W-1]};
        low_next = low_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = EDGE_W'(num[39:16]);
            low_next = num[15:0];
            dvs_next = divisor;
            q_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            low_next = {low_reg[NORM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = EDGE_W'(rem_sh - {1'b0, dvs_reg});
                q_next = {q_reg[NORM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[EDGE_W-1:0];
                q_next = {q_reg[NORM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(NORM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg <= q_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;

endmodule

// ----- design/polygon_min_separation_top.sv -----
// Top level of the polygon minimum separation block: vertex stores, sequencer,
// shared multiplier and output register. Depends on pms_pkg, pms_sqrt and pms_div.
//
// Input stream: tuser carries the command (load A vertex, load B vertex, compute),
// tdata carries the vertex coordinates. A load transfer is taken without leaving idle.
// A load into a full polygon drops the vertex and marks an overflow.
// A compute transfer starts the separating-axis search and holds s_axis_tready low
// until the result is in the output register. Per edge of A the search reads the
// stores, forms the squared edge length, takes its square root, runs two divides for
// the normal, projects each B vertex through the single shared multiplier and keeps
// the best edge; a zero-length edge skips the divides. It covers count_a edges in all.
// A compute with an error status goes straight to the output without the search.
// Output stream: one transfer per compute with the separation, normal and B vertex
// in tdata and the status in tuser. A stalled receiver holds the result in the
// output register; loads are still taken meanwhile, a following compute waits.
// Reset clears the vertex counts, the overflow flag and the output valid; the
// vertex stores are not cleared and are read only below the loaded counts.
module polygon_min_separation_top
    import pms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // vertex_x, vertex_y
    input  logic [1:0]   s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // separation, normal_x, normal_y, point_x, point_y
    output logic [1:0]   m_axis_tuser    // status
);

    logic [COORD_W-1:0] mem_a_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_a_y [MAX_VERTICES];
    logic [COORD_W-1:0] mem_b_x [MAX_VERTICES];
    logic [COORD_W-1:0] mem_b_y [MAX_VERTICES];
    logic [COORD_W-1:0] rd_ax_reg, rd_ay_reg, rd_bx_reg, rd_by_reg;
    logic [VIDX_W-1:0]  a_raddr, b_raddr;

    pms_state_t state_reg, state_next;
    logic [VIDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic              ovf_reg, ovf_next;
    logic              mv_reg, mv_next;
    logic [111:0]      md_reg, md_next;
    logic [1:0]        mu_reg, mu_next;

    logic signed [COORD_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [EDGE_W-1:0]  ex_reg, ex_next, ey_reg, ey_next;
    logic signed [EDGE_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [COORD_W-1:0]        bx_reg, bx_next, by_reg, by_next;
    logic signed [PROD_W-1:0]  prod_reg, sum_reg, sum_next;
    logic [EDGE_W-1:0]         len_reg, len_next;
    logic signed [NORM_W-1:0]  nx_reg, nx_next, ny_reg, ny_next;
    logic signed [PROJ_W-1:0]  mn_reg, mn_next, best_reg, best_next;
    logic [COORD_W-1:0]        mpx_reg, mpx_next, mpy_reg, mpy_next;
    logic signed [NORM_W-1:0]  bnx_reg, bnx_next, bny_reg, bny_next;
    logic [COORD_W-1:0]        bpx_reg, bpx_next, bpy_reg, bpy_next;
    logic [1:0]                status_reg, status_next;

    logic signed [EDGE_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  full;
    logic signed [PROJ_W-1:0]  proj;
    logic signed [SEP_W-1:0]   sep_sat;
    logic [CNT_W-1:0]          i_inc, j_inc;
    logic [VIDX_W-1:0]         i_wrap;
    logic                      acc, load_a, load_b;

    logic              sq_start, sq_done;
    logic [EDGE_W-1:0] sq_root;
    logic              dv_start, dv_done;
    logic [EDGE_W-1:0] dv_mag;
    logic [NORM_W-1:0] dv_q;

    pms_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (PROD_W'(sum_reg + prod_reg)),
        .done     (sq_done),
        .root     (sq_root)
    );

    pms_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .mag      (dv_mag),
        .divisor  (len_reg),
        .done     (dv_done),
        .quotient (dv_q)
    );

    function automatic logic signed [NORM_W-1:0] norm_fix(input logic [NORM_W-1:0] q,
                                                         input logic neg);
        logic signed [NORM_W:0] r;
        begin
            if (neg)
            begin
                r = -$signed({1'b0, q});
            end
            else if (q > NORM_W'(32767))
            begin
                r = (NORM_W+1)'(32767);
            end
            else
            begin
                r = $signed({1'b0, q});
            end
            return r[NORM_W-1:0];
        end
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;
    assign load_a = acc && (s_axis_tuser == CMD_LOAD_A) && (cnt_a_reg < CNT_W'(MAX_VERTICES));
    assign load_b = acc && (s_axis_tuser == CMD_LOAD_B) && (cnt_b_reg < CNT_W'(MAX_VERTICES));
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        i_inc = CNT_W'(i_reg) + CNT_W'(1);
        j_inc = CNT_W'(j_reg) + CNT_W'(1);
        i_wrap = (i_inc >= cnt_a_reg) ? '0 : i_inc[VIDX_W-1:0];
        full = sum_reg + prod_reg + PROD_W'(16384);
        proj = PROJ_W'(full >>> 15);
        if (best_reg > PROJ_W'(33554431))
        begin
            sep_sat = SEP_W'(33554431);
        end
        else if (best_reg < -PROJ_W'(33554432))
        begin
            sep_sat = -SEP_W'(33554432);
        end
        else
        begin
            sep_sat = best_reg[SEP_W-1:0];
        end

        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next = ovf_reg;
        mv_next = mv_reg && !m_axis_tready;
        md_next = md_reg;
        mu_next = mu_reg;
        ax_next = ax_reg;
        ay_next = ay_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        bx_next = bx_reg;
        by_next = by_reg;
        sum_next = sum_reg;
        len_next = len_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        mn_next = mn_reg;
        mpx_next = mpx_reg;
        mpy_next = mpy_reg;
        best_next = best_reg;
        bnx_next = bnx_reg;
        bny_next = bny_reg;
        bpx_next = bpx_reg;
        bpy_next = bpy_reg;
        status_next = status_reg;
        a_raddr = i_reg;
        b_raddr = j_reg;
        mul_a = ex_reg;
        mul_b = ex_reg;
        sq_start = 1'b0;
        dv_start = 1'b0;
        dv_mag = ey_reg[EDGE_W-1] ? EDGE_W'(-ey_reg) : EDGE_W'(ey_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (s_axis_tuser == CMD_LOAD_A)
                    begin
                        if (load_a)
                        begin
                            cnt_a_next = cnt_a_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (s_axis_tuser == CMD_LOAD_B)
                    begin
                        if (load_b)
                        begin
                            cnt_b_next = cnt_b_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (s_axis_tuser == CMD_COMPUTE)
                    begin
                        best_next = '0;
                        bnx_next = '0;
                        bny_next = '0;
                        bpx_next = '0;
                        bpy_next = '0;
                        i_next = '0;
                        if (ovf_reg)
                        begin
                            status_next = ST_OVERFLOW;
                            state_next = S_OUT;
                        end
                        else if (cnt_a_reg == '0)
                        begin
                            status_next = ST_A_EMPTY;
                            state_next = S_OUT;
                        end
                        else if (cnt_b_reg == '0)
                        begin
                            status_next = ST_B_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            status_next = ST_OK;
                            state_next = S_A0;
                        end
                    end
                end
            end
            S_A0:
            begin
                state_next = S_A1;
            end
            S_A1:
            begin
                ax_next = rd_ax_reg;
                ay_next = rd_ay_reg;
                a_raddr = i_wrap;
                state_next = S_A2;
            end
            S_A2:
            begin
                ex_next = EDGE_W'($signed(rd_ax_reg)) - EDGE_W'(ax_reg);
                ey_next = EDGE_W'($signed(rd_ay_reg)) - EDGE_W'(ay_reg);
                state_next = S_SQ0;
            end
            S_SQ0:
            begin
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                mul_a = ey_reg;
                mul_b = ey_reg;
                sum_next = prod_reg;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_start = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:
            begin
                if (sq_done)
                begin
                    len_next = sq_root;
                    state_next = S_DX;
                end
            end
            S_DX:
            begin
                if (len_reg == '0)
                begin
                    nx_next = '0;
                    ny_next = '0;
                    j_next = '0;
                    state_next = S_B0;
                end
                else
                begin
                    dv_start = 1'b1;
                    state_next = S_DXW;
                end
            end
            S_DXW:
            begin
                if (dv_done)
                begin
                    nx_next = norm_fix(dv_q, (ey_reg > 0));
                    state_next = S_DY;
                end
            end
            S_DY:
            begin
                dv_mag = ex_reg[EDGE_W-1] ? EDGE_W'(-ex_reg) : EDGE_W'(ex_reg);
                dv_start = 1'b1;
                state_next = S_DYW;
            end
            S_DYW:
            begin
                if (dv_done)
                begin
                    ny_next = norm_fix(dv_q, ex_reg[EDGE_W-1]);
                    j_next = '0;
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                state_next = S_B1;
            end
            S_B1:
            begin
                bx_next = rd_bx_reg;
                by_next = rd_by_reg;
                dx_next = EDGE_W'($signed(rd_bx_reg)) - EDGE_W'(ax_reg);
                dy_next = EDGE_W'($signed(rd_by_reg)) - EDGE_W'(ay_reg);
                state_next = S_P0;
            end
            S_P0:
            begin
                mul_a = dx_reg;
                mul_b = EDGE_W'(nx_reg);
                state_next = S_P1;
            end
            S_P1:
            begin
                mul_a = dy_reg;
                mul_b = EDGE_W'(ny_reg);
                sum_next = prod_reg;
                state_next = S_P2;
            end
            S_P2:
            begin
                if ((j_reg == '0) || (proj < mn_reg))
                begin
                    mn_next = proj;
                    mpx_next = bx_reg;
                    mpy_next = by_reg;
                end
                if (j_inc >= cnt_b_reg)
                begin
                    state_next = S_EDGE;
                end
                else
                begin
                    j_next = j_inc[VIDX_W-1:0];
                    state_next = S_B0;
                end
            end
            S_EDGE:
            begin
                if ((i_reg == '0) || (mn_reg > best_reg))
                begin
                    best_next = mn_reg;
                    bnx_next = nx_reg;
                    bny_next = ny_reg;
                    bpx_next = mpx_reg;
                    bpy_next = mpy_reg;
                end
                if (i_inc >= cnt_a_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    i_next = i_inc[VIDX_W-1:0];
                    state_next = S_A0;
                end
            end
            S_OUT:
            begin
                if (!mv_reg || m_axis_tready)
                begin
                    mv_next = 1'b1;
                    md_next = {6'd0, bpy_reg, bpx_reg, bny_reg, bnx_reg, sep_sat};
                    mu_next = status_reg;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            mem_a_x[cnt_a_reg[VIDX_W-1:0]] <= s_axis_tdata[23:0];
            mem_a_y[cnt_a_reg[VIDX_W-1:0]] <= s_axis_tdata[47:24];
        end
        if (load_b)
        begin
            mem_b_x[cnt_b_reg[VIDX_W-1:0]] <= s_axis_tdata[23:0];
            mem_b_y[cnt_b_reg[VIDX_W-1:0]] <= s_axis_tdata[47:24];
        end
        rd_ax_reg <= mem_a_x[a_raddr];
        rd_ay_reg <= mem_a_y[a_raddr];
        rd_bx_reg <= mem_b_x[b_raddr];
        rd_by_reg <= mem_b_y[b_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg <= 1'b0;
            mv_reg <= 1'b0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg <= ovf_next;
            mv_reg <= mv_next;
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg <= md_next;
        mu_reg <= mu_next;
        ax_reg <= ax_next;
        ay_reg <= ay_next;
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        bx_reg <= bx_next;
        by_reg <= by_next;
        prod_reg <= mul_p;
        sum_reg <= sum_next;
        len_reg <= len_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        mn_reg <= mn_next;
        mpx_reg <= mpx_next;
        mpy_reg <= mpy_next;
        best_reg <= best_next;
        bnx_reg <= bnx_next;
        bny_reg <= bny_next;
        bpx_reg <= bpx_next;
        bpy_reg <= bpy_next;
        status_reg <= status_next;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata = md_reg;
    assign m_axis_tuser = mu_reg;

    a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && s_axis_tuser == CMD_COMPUTE) |=> !s_axis_tready)
        else $error("input still ready after a compute transfer");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero data");

    a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(sq_done && dv_done))
        else $error("square root and divider finished together");

    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> (cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg))
        else $error("vertex counts not cleared with the result");

endmodule
